// ===== hw/rtl/qrm_pkg.sv =====
`timescale 1ns / 1ps

package qrm_pkg;

  localparam int COMPONENT_BITS = 16;
  localparam int WORK_BITS      = 30;
  localparam int OUT_FRAC       = 14;
  localparam int OUT_BITS       = 16;
  localparam int NUM_ENT        = 9;

  // element width after the optional narrowing of wide components
  localparam int EW        = (COMPONENT_BITS > WORK_BITS) ? WORK_BITS + 1 : COMPONENT_BITS;
  localparam int DROP      = COMPONENT_BITS - ((COMPONENT_BITS > WORK_BITS) ?
                                               WORK_BITS : COMPONENT_BITS);
  localparam int PW        = 2 * EW;
  localparam int DW        = 2 * EW + 1;
  localparam int NW        = 2 * EW + 2;
  localparam int RW        = DW + 1;
  localparam int QB        = OUT_FRAC + 2;
  localparam int PL_N      = QB + 2;
  localparam int IN_DATA_W = ((4 * COMPONENT_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((NUM_ENT * OUT_BITS + 7) / 8) * 8;

  typedef logic signed [EW-1:0] comp_t;
  typedef logic signed [PW-1:0] prod_t;
  typedef logic signed [NW-1:0] num_t;
  typedef logic signed [OUT_BITS-1:0] entry_t;

  typedef struct packed {
    prod_t xx;
    prod_t yy;
    prod_t zz;
    prod_t ww;
    prod_t xy;
    prod_t xz;
    prod_t yz;
    prod_t wx;
    prod_t wy;
    prod_t wz;
  } prods_t;

  typedef struct packed {
    logic [RW-1:0] rem;
    logic [QB-1:0] quo;
    logic          neg;
  } div_lane_t;

  typedef struct packed {
    div_lane_t [NUM_ENT-1:0] lane;
    logic [DW-1:0]           den;
    logic                    degen;
  } div_stage_t;

endpackage

// ===== hw/rtl/quaternion_to_rotation_matrix.sv =====
`timescale 1ns / 1ps

// throughput: one quaternion per cycle while out_tready does not hold the output; one
// product stage, a sum stage, a sign stage and sixteen one-bit restoring divide stages
// for the nine entries, then an output register. Stalls only fill pipeline holes, so
// in_tready drops only when every stage is full
// reset: synchronous active-low rst_n clears all stage valid bits; data is not reset

module quaternion_to_rotation_matrix
  import qrm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // quat_x, quat_y, quat_z, quat_w
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // m00, m01, m02, m10, m11, m12, m20, m21, m22
  output logic                  out_tuser   // degenerate
);

  localparam entry_t ONE = entry_t'(1) <<< OUT_FRAC;

  function automatic comp_t comp_of(logic [COMPONENT_BITS-1:0] v);
    logic                      neg;
    logic [COMPONENT_BITS-1:0] mag;
    logic [EW-1:0]             m;
    neg = v[COMPONENT_BITS-1];
    mag = neg ? ((~v) + {{(COMPONENT_BITS-1){1'b0}}, 1'b1}) : v;
    m   = EW'(mag >> DROP);
    return comp_t'(neg ? ((~m) + {{(EW-1){1'b0}}, 1'b1}) : m);
  endfunction

  function automatic div_lane_t div_step(div_lane_t a, logic [DW-1:0] d, logic sh);
    logic [RW-1:0] r;
    div_lane_t     o;
    r     = sh ? {a.rem[RW-2:0], 1'b0} : a.rem;
    o.neg = a.neg;
    if (r >= {1'b0, d}) begin
      o.rem = r - {1'b0, d};
      o.quo = {a.quo[QB-2:0], 1'b1};
    end else begin
      o.rem = r;
      o.quo = {a.quo[QB-2:0], 1'b0};
    end
    return o;
  endfunction

  // handshake chain
  logic            prod_v_r;
  prods_t          prod_r, prod_nxt;
  logic [PL_N-1:0] pl_v_r;
  div_stage_t      pl_r   [PL_N];
  div_stage_t      pl_nxt [PL_N];
  logic            out_v_r;
  entry_t [NUM_ENT-1:0] out_m_r, out_m_nxt;
  logic            degen_r;

  logic            go_out, go_prod;
  logic [PL_N-1:0] go_pl;

  always_comb begin
    go_out = !out_v_r || out_tready;
    go_pl[PL_N-1] = !pl_v_r[PL_N-1] || go_out;
    for (int i = PL_N - 2; i >= 0; i--) begin
      go_pl[i] = !pl_v_r[i] || go_pl[i+1];
    end
    go_prod = !prod_v_r || go_pl[0];
  end

  assign in_tready = go_prod;

  // products
  comp_t qx, qy, qz, qw;

  always_comb begin
    qx = comp_of(in_tdata[0*COMPONENT_BITS +: COMPONENT_BITS]);
    qy = comp_of(in_tdata[1*COMPONENT_BITS +: COMPONENT_BITS]);
    qz = comp_of(in_tdata[2*COMPONENT_BITS +: COMPONENT_BITS]);
    qw = comp_of(in_tdata[3*COMPONENT_BITS +: COMPONENT_BITS]);
    prod_nxt.xx = prod_t'(qx) * prod_t'(qx);
    prod_nxt.yy = prod_t'(qy) * prod_t'(qy);
    prod_nxt.zz = prod_t'(qz) * prod_t'(qz);
    prod_nxt.ww = prod_t'(qw) * prod_t'(qw);
    prod_nxt.xy = prod_t'(qx) * prod_t'(qy);
    prod_nxt.xz = prod_t'(qx) * prod_t'(qz);
    prod_nxt.yz = prod_t'(qy) * prod_t'(qz);
    prod_nxt.wx = prod_t'(qw) * prod_t'(qx);
    prod_nxt.wy = prod_t'(qw) * prod_t'(qy);
    prod_nxt.wz = prod_t'(qw) * prod_t'(qz);
  end

  // numerators and norm, sign removal, divide steps
  num_t n [NUM_ENT];
  num_t den_full;

  always_comb begin
    n[0] = num_t'(prod_r.xx) + num_t'(prod_r.ww) - num_t'(prod_r.yy) - num_t'(prod_r.zz);
    n[1] = (num_t'(prod_r.xy) - num_t'(prod_r.wz)) <<< 1;
    n[2] = (num_t'(prod_r.xz) + num_t'(prod_r.wy)) <<< 1;
    n[3] = (num_t'(prod_r.xy) + num_t'(prod_r.wz)) <<< 1;
    n[4] = num_t'(prod_r.yy) + num_t'(prod_r.ww) - num_t'(prod_r.xx) - num_t'(prod_r.zz);
    n[5] = (num_t'(prod_r.yz) - num_t'(prod_r.wx)) <<< 1;
    n[6] = (num_t'(prod_r.xz) - num_t'(prod_r.wy)) <<< 1;
    n[7] = (num_t'(prod_r.yz) + num_t'(prod_r.wx)) <<< 1;
    n[8] = num_t'(prod_r.zz) + num_t'(prod_r.ww) - num_t'(prod_r.xx) - num_t'(prod_r.yy);
    den_full = num_t'(prod_r.xx) + num_t'(prod_r.yy) + num_t'(prod_r.zz)
             + num_t'(prod_r.ww);

    pl_nxt[0].den   = den_full[DW-1:0];
    pl_nxt[0].degen = (den_full == '0);
    for (int k = 0; k < NUM_ENT; k++) begin
      pl_nxt[0].lane[k].rem = RW'(n[k]);
      pl_nxt[0].lane[k].quo = '0;
      pl_nxt[0].lane[k].neg = 1'b0;
    end

    pl_nxt[1].den   = pl_r[0].den;
    pl_nxt[1].degen = pl_r[0].degen;
    for (int k = 0; k < NUM_ENT; k++) begin
      pl_nxt[1].lane[k].neg = pl_r[0].lane[k].rem[RW-1];
      pl_nxt[1].lane[k].rem = pl_r[0].lane[k].rem[RW-1] ?
                              ((~pl_r[0].lane[k].rem) + {{(RW-1){1'b0}}, 1'b1}) :
                              pl_r[0].lane[k].rem;
      pl_nxt[1].lane[k].quo = '0;
    end

    for (int i = 2; i < PL_N; i++) begin
      pl_nxt[i].den   = pl_r[i-1].den;
      pl_nxt[i].degen = pl_r[i-1].degen;
      for (int k = 0; k < NUM_ENT; k++) begin
        pl_nxt[i].lane[k] = div_step(pl_r[i-1].lane[k], pl_r[i-1].den, (i != 2));
      end
    end
  end

  // rounding and identity override
  logic [QB:0]    rnd [NUM_ENT];
  logic [QB-1:0]  rmag [NUM_ENT];

  always_comb begin
    for (int k = 0; k < NUM_ENT; k++) begin
      rnd[k]  = {1'b0, pl_r[PL_N-1].lane[k].quo} + {{QB{1'b0}}, 1'b1};
      rmag[k] = rnd[k][QB:1];
      if (pl_r[PL_N-1].degen) begin
        out_m_nxt[k] = ((k == 0) || (k == 4) || (k == 8)) ? ONE : '0;
      end else if (pl_r[PL_N-1].lane[k].neg) begin
        out_m_nxt[k] = -entry_t'(rmag[k]);
      end else begin
        out_m_nxt[k] = entry_t'(rmag[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_v_r <= 1'b0;
      pl_v_r   <= '0;
      out_v_r  <= 1'b0;
    end else begin
      if (go_prod) begin
        prod_v_r <= in_tvalid;
      end
      if (go_pl[0]) begin
        pl_v_r[0] <= prod_v_r;
      end
      for (int i = 1; i < PL_N; i++) begin
        if (go_pl[i]) begin
          pl_v_r[i] <= pl_v_r[i-1];
        end
      end
      if (go_out) begin
        out_v_r <= pl_v_r[PL_N-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go_prod) begin
      prod_r <= prod_nxt;
    end
    if (go_pl[0]) begin
      pl_r[0] <= pl_nxt[0];
    end
    for (int i = 1; i < PL_N; i++) begin
      if (go_pl[i]) begin
        pl_r[i] <= pl_nxt[i];
      end
    end
    if (go_out) begin
      out_m_r <= out_m_nxt;
      degen_r <= pl_r[PL_N-1].degen;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = OUT_DATA_W'(out_m_r);
  assign out_tuser  = degen_r;

  // checks
  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> prod_v_r)
    else $error("accepted quaternion did not enter the product stage");

  a_prod_hold: assert property (@(posedge clk) disable iff (!rst_n)
    prod_v_r && !go_pl[0] |=> prod_v_r && $stable(prod_r))
    else $error("stalled product stage lost or changed its data");

  a_degen_identity: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && degen_r |-> out_m_r[0] == ONE && out_m_r[4] == ONE && out_m_r[8] == ONE
      && out_m_r[1] == '0 && out_m_r[2] == '0 && out_m_r[3] == '0
      && out_m_r[5] == '0 && out_m_r[6] == '0 && out_m_r[7] == '0)
    else $error("degenerate result is not the identity");

  a_entry_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> $signed(out_m_r[0]) <= ONE && $signed(out_m_r[0]) >= -ONE
      && $signed(out_m_r[1]) <= ONE && $signed(out_m_r[1]) >= -ONE
      && $signed(out_m_r[8]) <= ONE && $signed(out_m_r[8]) >= -ONE)
    else $error("matrix entry outside unit range");

endmodule
